@@ rtl/gtpp_pkg.sv @@
package gtpp_pkg;

  localparam int unsigned IdxW = 14;
  localparam logic [IdxW-1:0] MAX_DATAGRAM_BYTES = 14'd8192;

  localparam logic [IdxW-1:0] POS_FLAGS  = 14'd0;
  localparam logic [IdxW-1:0] POS_TYPE   = 14'd1;
  localparam logic [IdxW-1:0] POS_LEN_HI = 14'd2;
  localparam logic [IdxW-1:0] POS_LEN_LO = 14'd3;
  localparam logic [IdxW-1:0] POS_SEQ_HI = 14'd4;
  localparam logic [IdxW-1:0] POS_SEQ_LO = 14'd5;
  localparam logic [15:0]     HDR_BYTES  = 16'd6;

  localparam logic [2:0] VERSION_MASK = 3'h7;
  localparam logic [2:0] VERSION_ONE  = 3'd1;
  localparam logic [2:0] VERSION_TWO  = 3'd2;
  localparam logic [7:0] LONG_TAG_MIN = 8'd128;

  localparam logic [1:0] CFG_CAUSE_TAG    = 2'd0;
  localparam logic [1:0] CFG_RECOVERY_TAG = 2'd1;
  localparam logic [1:0] CFG_XFER_CMD_TAG = 2'd2;

  localparam logic [6:0] CAUSE_TAG_RST    = 7'd1;
  localparam logic [6:0] RECOVERY_TAG_RST = 7'd14;
  localparam logic [6:0] XFER_CMD_TAG_RST = 7'd126;

  typedef enum logic [2:0] {
    PH_TAG      = 3'd0,
    PH_TV_VALUE = 3'd1,
    PH_LEN_HI   = 3'd2,
    PH_LEN_LO   = 3'd3,
    PH_SKIP     = 3'd4
  } gtpp_phase_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED    = 2'd0,
    ST_SHORT       = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_LEN_EXCEEDS = 2'd3
  } gtpp_status_e;

  typedef struct packed {
    logic [6:0] cause_tag;
    logic [6:0] recovery_tag;
    logic [6:0] xfer_cmd_tag;
  } gtpp_cfg_t;

  typedef struct packed {
    gtpp_status_e status;
    logic [7:0]   pdu_type;
    logic [15:0]  seq_number;
    logic [15:0]  payload_length;
    logic [7:0]   cause_value;
    logic         cause_present;
    logic [7:0]   recovery_value;
    logic         recovery_present;
    logic         ies_ok;
  } gtpp_result_t;

endpackage

@@ rtl/gtp_prime_message_parser.sv @@
// channel  dir  handshake                payload
// in       in   in_valid_i/in_ready_o    data_byte_i, last_byte_i
// out      out  out_valid_o/out_ready_i  status_o, pdu_type_o, seq_number_o,
//                                        payload_length_o, cause_*_o, recovery_*_o, ies_ok_o
// cfg      in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// one byte per cycle while no last byte waits: input register, one pass of parse logic, result register
// a result is loaded into the result register when its last byte leaves the input register
// only a last byte waits on the result register; other bytes never stall
// reset clears all datagram state and loads default tags; cfg is always ready
module gtp_prime_message_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  pdu_type_o,
  output logic [15:0] seq_number_o,
  output logic [15:0] payload_length_o,
  output logic [7:0]  cause_value_o,
  output logic        cause_present_o,
  output logic [7:0]  recovery_value_o,
  output logic        recovery_present_o,
  output logic        ies_ok_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  gtpp_pkg::gtpp_cfg_t    cfg;
  gtpp_pkg::gtpp_result_t result;
  gtpp_pkg::gtpp_result_t out_q;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       consume;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign consume     = in_valid_q && (!in_last_q || out_free);
  assign in_ready_o  = !in_valid_q || consume;

  gtpp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gtpp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (consume),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (consume && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    if (consume && in_last_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign pdu_type_o         = out_q.pdu_type;
  assign seq_number_o       = out_q.seq_number;
  assign payload_length_o   = out_q.payload_length;
  assign cause_value_o      = out_q.cause_value;
  assign cause_present_o    = out_q.cause_present;
  assign recovery_value_o   = out_q.recovery_value;
  assign recovery_present_o = out_q.recovery_present;
  assign ies_ok_o           = out_q.ies_ok;

  a_mid_bytes_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_last_q |-> consume)
    else $error("non-final byte held in input register");

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_last_q && out_valid_q && !out_ready_i |=>
      in_valid_q && in_last_q && $stable(in_byte_q))
    else $error("final byte lost while result register full");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_last_q |=> out_valid_q)
    else $error("final byte consumed without a result");

endmodule

@@ rtl/gtpp_cfg_regs.sv @@
module gtpp_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [6:0]        cfg_data_i,
  output gtpp_pkg::gtpp_cfg_t cfg_o
);

  gtpp_pkg::gtpp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        gtpp_pkg::CFG_CAUSE_TAG:    cfg_d.cause_tag    = cfg_data_i;
        gtpp_pkg::CFG_RECOVERY_TAG: cfg_d.recovery_tag = cfg_data_i;
        gtpp_pkg::CFG_XFER_CMD_TAG: cfg_d.xfer_cmd_tag = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cause_tag    <= gtpp_pkg::CAUSE_TAG_RST;
      cfg_q.recovery_tag <= gtpp_pkg::RECOVERY_TAG_RST;
      cfg_q.xfer_cmd_tag <= gtpp_pkg::XFER_CMD_TAG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/gtpp_parser.sv @@
module gtpp_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  input  gtpp_pkg::gtpp_cfg_t    cfg_i,
  output gtpp_pkg::gtpp_result_t result_o
);

  logic [gtpp_pkg::IdxW-1:0] byte_index_q, byte_index_d;
  logic                      version_bad_q, version_bad_d;
  logic [7:0]                type_q, type_d;
  logic [15:0]               length_q, length_d;
  logic [15:0]               sequence_q, sequence_d;
  gtpp_pkg::gtpp_phase_e     phase_q, phase_d;
  logic [15:0]               skip_q, skip_d;
  logic [7:0]                pending_tag_q, pending_tag_d;
  logic                      aborted_q, aborted_d;
  logic [7:0]                cause_val_q, cause_val_d;
  logic                      cause_pres_q, cause_pres_d;
  logic [7:0]                rec_val_q, rec_val_d;
  logic                      rec_pres_q, rec_pres_d;

  logic [7:0]  cause_tag8, rec_tag8, xfer_tag8;
  logic [2:0]  version;
  logic [15:0] payload_pos;
  logic [15:0] skip_lo;
  logic [15:0] skip_dec;
  gtpp_pkg::gtpp_status_e status;

  assign cause_tag8  = {1'b0, cfg_i.cause_tag};
  assign rec_tag8    = {1'b0, cfg_i.recovery_tag};
  assign xfer_tag8   = {1'b0, cfg_i.xfer_cmd_tag};
  assign version     = data_byte_i[7:5] & gtpp_pkg::VERSION_MASK;
  assign payload_pos = {2'b00, byte_index_q} - gtpp_pkg::HDR_BYTES;
  assign skip_lo     = skip_q | {8'h00, data_byte_i};
  assign skip_dec    = (skip_q != 16'd0) ? skip_q - 16'd1 : skip_q;

  always_comb begin
    byte_index_d  = byte_index_q;
    version_bad_d = version_bad_q;
    type_d        = type_q;
    length_d      = length_q;
    sequence_d    = sequence_q;
    phase_d       = phase_q;
    skip_d        = skip_q;
    pending_tag_d = pending_tag_q;
    aborted_d     = aborted_q;
    cause_val_d   = cause_val_q;
    cause_pres_d  = cause_pres_q;
    rec_val_d     = rec_val_q;
    rec_pres_d    = rec_pres_q;
    status        = gtpp_pkg::ST_ACCEPTED;
    result_o      = '0;

    if (step_i && (byte_index_q < gtpp_pkg::MAX_DATAGRAM_BYTES)) begin
      unique case (byte_index_q)
        gtpp_pkg::POS_FLAGS:
          version_bad_d = (version != gtpp_pkg::VERSION_ONE) &&
                          (version != gtpp_pkg::VERSION_TWO);
        gtpp_pkg::POS_TYPE:   type_d           = data_byte_i;
        gtpp_pkg::POS_LEN_HI: length_d[15:8]   = data_byte_i;
        gtpp_pkg::POS_LEN_LO: length_d[7:0]    = data_byte_i;
        gtpp_pkg::POS_SEQ_HI: sequence_d[15:8] = data_byte_i;
        gtpp_pkg::POS_SEQ_LO: sequence_d[7:0]  = data_byte_i;
        default: begin
          // element walk only inside the declared payload
          if ((payload_pos < length_q) && !aborted_q) begin
            unique case (phase_q)
              gtpp_pkg::PH_TAG: begin
                pending_tag_d = data_byte_i;
                if (data_byte_i >= gtpp_pkg::LONG_TAG_MIN) begin
                  phase_d = gtpp_pkg::PH_LEN_HI;
                end else if (data_byte_i == cause_tag8 || data_byte_i == rec_tag8 ||
                             data_byte_i == xfer_tag8) begin
                  phase_d = gtpp_pkg::PH_TV_VALUE;
                end else begin
                  aborted_d = 1'b1;
                end
              end
              gtpp_pkg::PH_TV_VALUE: begin
                // cause wins over recovery, transfer command value is dropped
                if (pending_tag_q == cause_tag8) begin
                  cause_val_d  = data_byte_i;
                  cause_pres_d = 1'b1;
                end else if (pending_tag_q == rec_tag8) begin
                  rec_val_d  = data_byte_i;
                  rec_pres_d = 1'b1;
                end
                phase_d = gtpp_pkg::PH_TAG;
              end
              gtpp_pkg::PH_LEN_HI: begin
                skip_d  = {data_byte_i, 8'h00};
                phase_d = gtpp_pkg::PH_LEN_LO;
              end
              gtpp_pkg::PH_LEN_LO: begin
                skip_d  = skip_lo;
                phase_d = (skip_lo == 16'd0) ? gtpp_pkg::PH_TAG : gtpp_pkg::PH_SKIP;
              end
              default: begin
                skip_d = skip_dec;
                if (skip_dec == 16'd0) begin
                  phase_d = gtpp_pkg::PH_TAG;
                end
              end
            endcase
          end
        end
      endcase
      byte_index_d = byte_index_q + 14'd1;
    end

    if (step_i && last_byte_i) begin
      if (byte_index_d < gtpp_pkg::HDR_BYTES[gtpp_pkg::IdxW-1:0]) begin
        status = gtpp_pkg::ST_SHORT;
      end else if (version_bad_d) begin
        status = gtpp_pkg::ST_BAD_VERSION;
      end else if (({1'b0, length_d} + {1'b0, gtpp_pkg::HDR_BYTES}) >
                   {3'b000, byte_index_d}) begin
        status = gtpp_pkg::ST_LEN_EXCEEDS;
      end else begin
        status = gtpp_pkg::ST_ACCEPTED;
      end

      result_o.status = status;
      if (status == gtpp_pkg::ST_ACCEPTED) begin
        result_o.pdu_type         = type_d;
        result_o.seq_number       = sequence_d;
        result_o.payload_length   = length_d;
        result_o.cause_value      = cause_val_d;
        result_o.cause_present    = cause_pres_d;
        result_o.recovery_value   = rec_val_d;
        result_o.recovery_present = rec_pres_d;
        result_o.ies_ok           = !aborted_d && (phase_d == gtpp_pkg::PH_TAG);
      end

      // datagram done, start over
      byte_index_d  = '0;
      version_bad_d = 1'b0;
      type_d        = '0;
      length_d      = '0;
      sequence_d    = '0;
      phase_d       = gtpp_pkg::PH_TAG;
      skip_d        = '0;
      pending_tag_d = '0;
      aborted_d     = 1'b0;
      cause_val_d   = '0;
      cause_pres_d  = 1'b0;
      rec_val_d     = '0;
      rec_pres_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q  <= '0;
      version_bad_q <= 1'b0;
      type_q        <= '0;
      length_q      <= '0;
      sequence_q    <= '0;
      phase_q       <= gtpp_pkg::PH_TAG;
      skip_q        <= '0;
      pending_tag_q <= '0;
      aborted_q     <= 1'b0;
      cause_val_q   <= '0;
      cause_pres_q  <= 1'b0;
      rec_val_q     <= '0;
      rec_pres_q    <= 1'b0;
    end else begin
      byte_index_q  <= byte_index_d;
      version_bad_q <= version_bad_d;
      type_q        <= type_d;
      length_q      <= length_d;
      sequence_q    <= sequence_d;
      phase_q       <= phase_d;
      skip_q        <= skip_d;
      pending_tag_q <= pending_tag_d;
      aborted_q     <= aborted_d;
      cause_val_q   <= cause_val_d;
      cause_pres_q  <= cause_pres_d;
      rec_val_q     <= rec_val_d;
      rec_pres_q    <= rec_pres_d;
    end
  end

  a_idx_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_index_q <= gtpp_pkg::MAX_DATAGRAM_BYTES)
    else $error("byte count past the saturation point");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> byte_index_q == '0 && !aborted_q && !cause_pres_q)
    else $error("datagram state not cleared after last byte");

  a_abort_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aborted_q && !(step_i && last_byte_i) |=> aborted_q)
    else $error("walk abort dropped inside a datagram");

endmodule

@@ tb/sv/gtpp_parse_checker.sv @@
module gtpp_parse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  pdu_type_i,
  input  logic [15:0] seq_number_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  cause_value_i,
  input  logic        cause_present_i,
  input  logic [7:0]  recovery_value_i,
  input  logic        recovery_present_i,
  input  logic        ies_ok_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int          error_count_o,
  output int          reports_due_o
);

  timeunit 1ns;
  timeprecision 1ps;

  gtpp_pkg::gtpp_cfg_t    tags;
  gtpp_pkg::gtpp_result_t pending_reports[$];

  logic [gtpp_pkg::IdxW-1:0] octet_count;
  logic                      ver_bad;
  logic [7:0]                hdr_type;
  logic [15:0]               hdr_length;
  logic [15:0]               hdr_seq;
  gtpp_pkg::gtpp_phase_e     phase;
  logic [15:0]               skip_left;
  logic [7:0]                tag_held;
  logic                      aborted;
  logic [7:0]                cause_val;
  logic                      cause_seen;
  logic [7:0]                rec_val;
  logic                      rec_seen;

  function automatic void clear_datagram_state();
    octet_count = '0;
    ver_bad     = 1'b0;
    hdr_type    = '0;
    hdr_length  = '0;
    hdr_seq     = '0;
    phase       = gtpp_pkg::PH_TAG;
    skip_left   = '0;
    tag_held    = '0;
    aborted     = 1'b0;
    cause_val   = '0;
    cause_seen  = 1'b0;
    rec_val     = '0;
    rec_seen    = 1'b0;
  endfunction

  function automatic void walk_octet(input logic [7:0] b);
    if (!aborted) begin
      case (phase)
        gtpp_pkg::PH_TAG: begin
          tag_held = b;
          if (b >= gtpp_pkg::LONG_TAG_MIN) begin
            phase = gtpp_pkg::PH_LEN_HI;
          end else if (b[6:0] == tags.cause_tag || b[6:0] == tags.recovery_tag ||
                       b[6:0] == tags.xfer_cmd_tag) begin
            phase = gtpp_pkg::PH_TV_VALUE;
          end else begin
            aborted = 1'b1;
          end
        end
        gtpp_pkg::PH_TV_VALUE: begin
          // cause takes precedence over recovery when the tags coincide
          if (tag_held[6:0] == tags.cause_tag) begin
            cause_val  = b;
            cause_seen = 1'b1;
          end else if (tag_held[6:0] == tags.recovery_tag) begin
            rec_val  = b;
            rec_seen = 1'b1;
          end
          phase = gtpp_pkg::PH_TAG;
        end
        gtpp_pkg::PH_LEN_HI: begin
          skip_left = {b, 8'h00};
          phase     = gtpp_pkg::PH_LEN_LO;
        end
        gtpp_pkg::PH_LEN_LO: begin
          skip_left = {skip_left[15:8], b};
          phase     = (skip_left == 16'd0) ? gtpp_pkg::PH_TAG : gtpp_pkg::PH_SKIP;
        end
        default: begin
          if (skip_left != 16'd0) skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) phase = gtpp_pkg::PH_TAG;
        end
      endcase
    end
  endfunction

  function automatic void parse_octet(input logic [7:0] b, input logic last);
    gtpp_pkg::gtpp_result_t rep;
    if (octet_count < gtpp_pkg::MAX_DATAGRAM_BYTES) begin
      case (octet_count)
        gtpp_pkg::POS_FLAGS:
          ver_bad = ((b[7:5] & gtpp_pkg::VERSION_MASK) != gtpp_pkg::VERSION_ONE) &&
                    ((b[7:5] & gtpp_pkg::VERSION_MASK) != gtpp_pkg::VERSION_TWO);
        gtpp_pkg::POS_TYPE:   hdr_type = b;
        gtpp_pkg::POS_LEN_HI: hdr_length[15:8] = b;
        gtpp_pkg::POS_LEN_LO: hdr_length[7:0] = b;
        gtpp_pkg::POS_SEQ_HI: hdr_seq[15:8] = b;
        gtpp_pkg::POS_SEQ_LO: hdr_seq[7:0] = b;
        default: begin
          if (int'(octet_count) - int'(gtpp_pkg::HDR_BYTES) < int'(hdr_length))
            walk_octet(b);
        end
      endcase
      octet_count = octet_count + 1'b1;
    end
    if (last) begin
      rep = '0;
      if (int'(octet_count) < int'(gtpp_pkg::HDR_BYTES)) begin
        rep.status = gtpp_pkg::ST_SHORT;
      end else if (ver_bad) begin
        rep.status = gtpp_pkg::ST_BAD_VERSION;
      end else if (int'(hdr_length) + int'(gtpp_pkg::HDR_BYTES) > int'(octet_count)) begin
        rep.status = gtpp_pkg::ST_LEN_EXCEEDS;
      end else begin
        rep.status           = gtpp_pkg::ST_ACCEPTED;
        rep.pdu_type         = hdr_type;
        rep.seq_number       = hdr_seq;
        rep.payload_length   = hdr_length;
        rep.cause_value      = cause_val;
        rep.cause_present    = cause_seen;
        rep.recovery_value   = rec_val;
        rep.recovery_present = rec_seen;
        rep.ies_ok           = !aborted && (phase == gtpp_pkg::PH_TAG);
      end
      pending_reports.push_back(rep);
      clear_datagram_state();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gtpp_pkg::gtpp_result_t want;
    gtpp_pkg::gtpp_result_t seen;
    if (!rst_ni) begin
      tags.cause_tag    = gtpp_pkg::CAUSE_TAG_RST;
      tags.recovery_tag = gtpp_pkg::RECOVERY_TAG_RST;
      tags.xfer_cmd_tag = gtpp_pkg::XFER_CMD_TAG_RST;
      clear_datagram_state();
      pending_reports.delete();
      error_count_o = 0;
      reports_due_o = 0;
    end else begin
      // results first, so a report pushed at this edge cannot match an output at it
      if (out_valid_i && out_ready_i) begin
        seen.status           = gtpp_pkg::gtpp_status_e'(status_i);
        seen.pdu_type         = pdu_type_i;
        seen.seq_number       = seq_number_i;
        seen.payload_length   = payload_length_i;
        seen.cause_value      = cause_value_i;
        seen.cause_present    = cause_present_i;
        seen.recovery_value   = recovery_value_i;
        seen.recovery_present = recovery_present_i;
        seen.ies_ok           = ies_ok_i;
        if (pending_reports.size() == 0) begin
          if (error_count_o < 10)
            $display("%0t: result transaction with none outstanding, status %0d",
                     $realtime, status_i);
          error_count_o++;
        end else begin
          want = pending_reports.pop_front();
          if (seen.status !== want.status || seen.pdu_type !== want.pdu_type ||
              seen.seq_number !== want.seq_number ||
              seen.payload_length !== want.payload_length ||
              seen.cause_value !== want.cause_value ||
              seen.cause_present !== want.cause_present ||
              seen.recovery_value !== want.recovery_value ||
              seen.recovery_present !== want.recovery_present ||
              seen.ies_ok !== want.ies_ok) begin
            if (error_count_o < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  want st=%0d type=%h seq=%h len=%h cause=%h/%b rec=%h/%b ok=%b",
                       want.status, want.pdu_type, want.seq_number, want.payload_length,
                       want.cause_value, want.cause_present, want.recovery_value,
                       want.recovery_present, want.ies_ok);
              $display("  got  st=%0d type=%h seq=%h len=%h cause=%h/%b rec=%h/%b ok=%b",
                       seen.status, seen.pdu_type, seen.seq_number, seen.payload_length,
                       seen.cause_value, seen.cause_present, seen.recovery_value,
                       seen.recovery_present, seen.ies_ok);
            end
            error_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          gtpp_pkg::CFG_CAUSE_TAG:    tags.cause_tag    = cfg_data_i;
          gtpp_pkg::CFG_RECOVERY_TAG: tags.recovery_tag = cfg_data_i;
          gtpp_pkg::CFG_XFER_CMD_TAG: tags.xfer_cmd_tag = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) parse_octet(data_byte_i, last_byte_i);
      reports_due_o = pending_reports.size();
    end
  end

endmodule

@@ tb/sv/tb_gtp_prime_message_parser.sv @@
module tb_gtp_prime_message_parser;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  localparam logic [7:0] FLAGS_V1      = {gtpp_pkg::VERSION_ONE, 5'h00};
  localparam logic [7:0] FLAGS_V2      = {gtpp_pkg::VERSION_TWO, 5'h1F};
  localparam logic [7:0] TAG_CAUSE     = {1'b0, gtpp_pkg::CAUSE_TAG_RST};
  localparam logic [7:0] TAG_REC       = {1'b0, gtpp_pkg::RECOVERY_TAG_RST};
  localparam logic [7:0] TAG_XFER      = {1'b0, gtpp_pkg::XFER_CMD_TAG_RST};
  localparam logic [7:0] TAG_STRAY     = 8'h05;
  localparam logic [7:0] TAG_LONG_LOW  = gtpp_pkg::LONG_TAG_MIN;
  localparam logic [7:0] TAG_LONG_HIGH = 8'hFF;
  localparam logic [15:0] FULL_PAYLOAD =
    16'(gtpp_pkg::MAX_DATAGRAM_BYTES) - gtpp_pkg::HDR_BYTES;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_pattern_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  pdu_type_o;
  logic [15:0] seq_number_o;
  logic [15:0] payload_length_o;
  logic [7:0]  cause_value_o;
  logic        cause_present_o;
  logic [7:0]  recovery_value_o;
  logic        recovery_present_o;
  logic        ies_ok_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [6:0]  cfg_data_i;

  int                  error_count;
  int                  reports_due;
  int                  cycle_count = 0;
  int                  burst_left = 0;
  gtpp_pkg::gtpp_cfg_t tag_set;
  logic [7:0]          dgram[$];

  rx_pattern_e rx_pattern = RX_OPEN;
  int          rx_hold = 0;
  logic [1:0]  rx_tick = '0;

  gtp_prime_message_parser DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .pdu_type_o         (pdu_type_o),
    .seq_number_o       (seq_number_o),
    .payload_length_o   (payload_length_o),
    .cause_value_o      (cause_value_o),
    .cause_present_o    (cause_present_o),
    .recovery_value_o   (recovery_value_o),
    .recovery_present_o (recovery_present_o),
    .ies_ok_o           (ies_ok_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  gtpp_parse_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_i           (status_o),
    .pdu_type_i         (pdu_type_o),
    .seq_number_i       (seq_number_o),
    .payload_length_i   (payload_length_o),
    .cause_value_i      (cause_value_o),
    .cause_present_i    (cause_present_o),
    .recovery_value_i   (recovery_value_o),
    .recovery_present_i (recovery_present_o),
    .ies_ok_i           (ies_ok_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .error_count_o      (error_count),
    .reports_due_o      (reports_due)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, reports_due);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side backpressure, switching between patterns of random duration
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 2'd1;
    if (rx_hold == 0) begin
      rx_pattern <= rx_pattern_e'(2'($urandom_range(0, 3)));
      rx_hold    <= $urandom_range(16, 160);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_pattern)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= (rx_tick == 2'd0);
      default:   out_ready_i <= ~out_ready_i;
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  task automatic send_datagram();
    for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1);
  endtask

  // idle the input and let every outstanding result drain
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (reports_due != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_beat(input logic [1:0] idx, input logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_tags(input gtpp_pkg::gtpp_cfg_t c);
    cfg_beat(gtpp_pkg::CFG_CAUSE_TAG, c.cause_tag);
    cfg_beat(gtpp_pkg::CFG_RECOVERY_TAG, c.recovery_tag);
    cfg_beat(gtpp_pkg::CFG_XFER_CMD_TAG, c.xfer_cmd_tag);
    cfg_valid_i <= 1'b0;
    tag_set = c;
  endtask

  task automatic push_header(input logic [7:0] flags, input logic [7:0] kind,
                             input logic [15:0] plen, input logic [15:0] seq);
    dgram.push_back(flags);
    dgram.push_back(kind);
    dgram.push_back(plen[15:8]);
    dgram.push_back(plen[7:0]);
    dgram.push_back(seq[15:8]);
    dgram.push_back(seq[7:0]);
  endtask

  function automatic logic [7:0] stray_tag();
    logic [6:0] t;
    do t = 7'($urandom_range(0, 127));
    while (t == tag_set.cause_tag || t == tag_set.recovery_tag || t == tag_set.xfer_cmd_tag);
    return {1'b0, t};
  endfunction

  // one long element spanning the whole payload, plus bytes past the counting limit
  task automatic build_oversize(input logic [15:0] plen);
    logic [15:0] span;
    span = FULL_PAYLOAD - 16'd3;
    dgram.delete();
    push_header(FLAGS_V1, 8'h42, plen, 16'h1234);
    dgram.push_back(8'hC0);
    dgram.push_back(span[15:8]);
    dgram.push_back(span[7:0]);
    repeat (int'(span) + 2) dgram.push_back(8'($urandom));
  endtask

  task automatic build_random_datagram();
    logic [7:0]  body[$];
    logic [15:0] plen;
    logic [2:0]  ver;
    int          n;
    int          pick;
    int          span;
    dgram.delete();
    if ($urandom_range(0, 99) < 15) begin
      // noise: random octets, sometimes with a plausible header
      n = $urandom_range(1, 24);
      repeat (n) dgram.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 1) dgram[0] = {3'($urandom_range(1, 2)), 5'($urandom)};
      if (n >= 4 && $urandom_range(0, 1) == 1) begin
        dgram[2] = 8'h00;
        dgram[3] = 8'($urandom_range(0, n));
      end
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          body.push_back({1'b0, tag_set.cause_tag});
          body.push_back(8'($urandom));
        end else if (pick < 45) begin
          body.push_back({1'b0, tag_set.recovery_tag});
          body.push_back(8'($urandom));
        end else if (pick < 55) begin
          body.push_back({1'b0, tag_set.xfer_cmd_tag});
          body.push_back(8'($urandom));
        end else if (pick < 60) begin
          body.push_back(stray_tag());
          body.push_back(8'($urandom));
        end else begin
          // a huge span runs past the payload end
          span = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 65535)
                                              : $urandom_range(0, 5);
          body.push_back(8'($urandom_range(128, 255)));
          body.push_back(span[15:8]);
          body.push_back(span[7:0]);
          if (span < 256) repeat (span) body.push_back(8'($urandom));
        end
      end
      plen = 16'(body.size());
      pick = $urandom_range(0, 99);
      if (pick < 8 && body.size() > 0) plen = 16'($urandom_range(0, body.size() - 1));
      else if (pick < 14) plen = plen + 16'($urandom_range(1, 3));
      // 3'(8) wraps to version 0
      ver = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(3, 8))
                                         : 3'($urandom_range(1, 2));
      push_header({ver, 5'($urandom)}, 8'($urandom), plen, 16'($urandom));
      foreach (body[i]) dgram.push_back(body[i]);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) dgram.push_back(8'($urandom));
    end
  endtask

  initial begin
    gtpp_pkg::gtpp_cfg_t phase_tags[6];
    int                  phase_bytes;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    last_byte_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= gtpp_pkg::CFG_CAUSE_TAG;
    cfg_data_i  <= '0;
    tag_set.cause_tag    = gtpp_pkg::CAUSE_TAG_RST;
    tag_set.recovery_tag = gtpp_pkg::RECOVERY_TAG_RST;
    tag_set.xfer_cmd_tag = gtpp_pkg::XFER_CMD_TAG_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // too short, short with bad version, bad versions 0 and 7, length beyond datagram
    dgram = '{8'hFF};
    send_datagram();
    dgram = '{8'h00, 8'h00, 8'h00};
    send_datagram();
    dgram = '{8'h1F, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
    send_datagram();
    dgram = '{8'hE0, 8'h01, 8'h00, 8'h05, 8'h00, 8'h01};
    send_datagram();
    dgram = '{FLAGS_V1, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF};
    send_datagram();
    // every element kind, empty long element, trailing octet ignored
    dgram = '{FLAGS_V2, 8'h00, 8'h00, 8'h0E, 8'h00, 8'h00, TAG_CAUSE, 8'hFF, TAG_REC, 8'h00,
              TAG_XFER, 8'hAA, TAG_LONG_LOW, 8'h00, 8'h00, TAG_LONG_HIGH, 8'h00, 8'h02,
              8'h55, 8'h55, 8'h7E};
    send_datagram();
    // repeated cause, then an unknown tag aborts the walk
    dgram = '{FLAGS_V1, 8'h10, 8'h00, 8'h06, 8'h12, 8'h34, TAG_CAUSE, 8'h11, TAG_CAUSE, 8'h22,
              TAG_STRAY, TAG_REC};
    send_datagram();
    // elements cut by payload end: missing value, missing length octet, skip overrun
    dgram = '{FLAGS_V1, 8'h20, 8'h00, 8'h01, 8'h00, 8'h01, TAG_CAUSE};
    send_datagram();
    dgram = '{FLAGS_V1, 8'h21, 8'h00, 8'h02, 8'h00, 8'h02, 8'h90, 8'h00};
    send_datagram();
    dgram = '{FLAGS_V2, 8'h22, 8'h00, 8'h04, 8'h00, 8'h03, 8'h90, 8'h00, 8'h05, 8'h01};
    send_datagram();
    // byte count saturation: exact fit passes, one more declared octet fails
    build_oversize(FULL_PAYLOAD);
    send_datagram();
    build_oversize(FULL_PAYLOAD + 16'd1);
    send_datagram();

    phase_tags[0] = '{7'd0, 7'd127, 7'd126};
    phase_tags[1] = '{7'd127, 7'd0, 7'd64};
    phase_tags[2] = '{7'd5, 7'd5, 7'd5};
    phase_tags[3] = '{7'd20, 7'd30, 7'd20};
    phase_tags[4] = '{7'd33, 7'd44, 7'd44};
    phase_tags[5] = '{7'($urandom), 7'($urandom), 7'($urandom)};
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      load_tags(phase_tags[p]);
      phase_bytes = 0;
      while (phase_bytes < 285) begin
        build_random_datagram();
        phase_bytes += dgram.size();
        send_datagram();
      end
    end
    wait_drained();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/gtpp_pkg.sv
rtl/gtpp_cfg_regs.sv
rtl/gtpp_parser.sv
rtl/gtp_prime_message_parser.sv
tb/sv/gtpp_parse_checker.sv
tb/sv/tb_gtp_prime_message_parser.sv
